FILE: design/mtfkc_pkg.sv
// Shared types and constants of the move-to-front key cache.
`default_nettype none

package mtfkc_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 3;
    localparam int CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_PRESENT  = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_HIT      = 3'd3,
        STATUS_MISS     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_FRONT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: design/mtfkc_if.sv
// Handshake channels of the move-to-front key cache: request, response, configuration.
`default_nettype none

interface mtfkc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [mtfkc_pkg::KEY_W-1:0]   key;
    logic [mtfkc_pkg::VALUE_W-1:0] put_value;

    modport source (output valid, command, key, put_value, input ready);
    modport sink   (input valid, command, key, put_value, output ready);
endinterface

interface mtfkc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mtfkc_pkg::STATUS_W-1:0] status;
    logic [mtfkc_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, status, read_value, input ready);
    modport sink   (input valid, status, read_value, output ready);
endinterface

interface mtfkc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mtfkc_pkg::CAP_W-1:0] capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

`default_nettype wire

FILE: design/move_to_front_key_cache_top.sv
// Top level of the move-to-front key cache.
`default_nettype none

// A small key/value cache held as an ordered list in two RAMs (keys and
// values) with one write port and one registered read port each. A put
// searches the filled entries; a key already held answers "present",
// otherwise the item is appended at the tail or refused when the fill has
// reached capacity_in_use (saturated to MAX_ENTRIES). A get searches from
// the front; on a hit the value is returned and the entry moves to the
// front, the entries ahead of it sliding back one place. One item is in
// work at a time and req.ready is low until it is finished. An item passes
// through an accept step, a scan of the entries compared (at most the fill),
// a decide step on a miss, shift steps for the entries ahead and a front write
// on a get hit at position p > 0, and a result step. The single RAM read
// port serves one entry per cycle for both the scan and the shift. A finished
// result sits in an output register, so the next item is taken while it
// waits for rsp.ready. Configuration is always ready; the capacity register
// resets to 16.
module move_to_front_key_cache_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    mtfkc_req_if.sink   req,
    mtfkc_rsp_if.source rsp,
    mtfkc_cfg_if.sink   cfg
);

    // index, fill-count and compare widths
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = (KEY_BITS < mtfkc_pkg::KEY_W) ? KEY_BITS : mtfkc_pkg::KEY_W;
    localparam int MW = (CW > mtfkc_pkg::CAP_W) ? CW : mtfkc_pkg::CAP_W;

    localparam int VW = mtfkc_pkg::VALUE_W;

    // list storage, front at address 0
    logic [KW-1:0] key_mem [MAX_ENTRIES];
    logic [VW-1:0] val_mem [MAX_ENTRIES];

    mtfkc_pkg::state_t  state_reg, state_next;
    logic               cmd_reg;
    logic [KW-1:0]      key_reg;
    logic [VW-1:0]      val_reg;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [mtfkc_pkg::CAP_W-1:0] cap_reg;

    mtfkc_pkg::status_t pend_status_reg, pend_status_next;
    logic [VW-1:0]      pend_value_reg, pend_value_next;

    logic               out_valid_reg, out_valid_next;
    mtfkc_pkg::status_t out_status_reg, out_status_next;
    logic [VW-1:0]      out_value_reg, out_value_next;

    // RAM ports
    logic [IW-1:0]      rd_addr;
    logic [KW-1:0]      rd_key_reg;
    logic [VW-1:0]      rd_val_reg;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [KW-1:0]      wr_key;
    logic [VW-1:0]      wr_val;

    logic               req_ready;
    logic               req_take;
    logic               key_hit;
    logic               scan_last;
    logic               list_full;

    assign req_take  = req.valid && req_ready;
    assign key_hit   = (rd_key_reg == key_reg);
    // current scan index is the last filled entry
    assign scan_last = ((CW'(idx_reg) + CW'(1)) == fill_reg);
    // capacity check; a register value above the store saturates
    assign list_full = (MW'(fill_reg) >= MW'(cap_reg)) ||
                       (fill_reg >= CW'(MAX_ENTRIES));

    assign req.ready      = req_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign cfg.ready      = 1'b1;

    // RAMs: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    // item payload, latched on accept
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg <= req.command;
            key_reg <= req.key[KW-1:0];
            val_reg <= req.put_value;
        end
        idx_reg         <= idx_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        out_status_reg  <= out_status_next;
        out_value_reg   <= out_value_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtfkc_pkg::ST_IDLE;
            fill_reg      <= '0;
            cap_reg       <= mtfkc_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity_in_use;
            end
        end
    end

    // sequencer: scan, then either append, slide entries back, or just report
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        fill_next        = fill_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        req_ready        = 1'b0;
        rd_addr          = idx_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_key           = key_reg;
        wr_val           = val_reg;

        case (state_reg)
            mtfkc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_addr   = '0;     // prime the scan with the front entry
                if (req.valid)
                begin
                    idx_next   = '0;
                    state_next = (fill_reg == '0) ? mtfkc_pkg::ST_DECIDE
                                                  : mtfkc_pkg::ST_SCAN;
                end
            end

            mtfkc_pkg::ST_SCAN:
            begin
                // read data belongs to idx_reg; fetch the next one meanwhile
                rd_addr = idx_reg + IW'(1);
                if (key_hit)
                begin
                    if (cmd_reg == mtfkc_pkg::CMD_PUT)
                    begin
                        pend_status_next = mtfkc_pkg::STATUS_PRESENT;
                        pend_value_next  = '0;
                        state_next       = mtfkc_pkg::ST_DONE;
                    end
                    else
                    begin
                        pend_status_next = mtfkc_pkg::STATUS_HIT;
                        pend_value_next  = rd_val_reg;
                        if (idx_reg == '0)
                        begin
                            state_next = mtfkc_pkg::ST_DONE;
                        end
                        else
                        begin
                            rd_addr    = idx_reg - IW'(1);
                            idx_next   = idx_reg - IW'(1);
                            state_next = mtfkc_pkg::ST_SHIFT;
                        end
                    end
                end
                else if (scan_last)
                begin
                    state_next = mtfkc_pkg::ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            mtfkc_pkg::ST_DECIDE:
            begin
                pend_value_next = '0;
                if (cmd_reg == mtfkc_pkg::CMD_GET)
                begin
                    pend_status_next = mtfkc_pkg::STATUS_MISS;
                end
                else if (list_full)
                begin
                    pend_status_next = mtfkc_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = IW'(fill_reg);
                    fill_next        = fill_reg + CW'(1);
                    pend_status_next = mtfkc_pkg::STATUS_INSERTED;
                end
                state_next = mtfkc_pkg::ST_DONE;
            end

            mtfkc_pkg::ST_SHIFT:
            begin
                // entry idx_reg moves back one place
                wr_en   = 1'b1;
                wr_addr = idx_reg + IW'(1);
                wr_key  = rd_key_reg;
                wr_val  = rd_val_reg;
                if (idx_reg == '0)
                begin
                    state_next = mtfkc_pkg::ST_FRONT;
                end
                else
                begin
                    rd_addr  = idx_reg - IW'(1);
                    idx_next = idx_reg - IW'(1);
                end
            end

            mtfkc_pkg::ST_FRONT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_key     = key_reg;
                wr_val     = pend_value_reg;
                state_next = mtfkc_pkg::ST_DONE;
            end

            mtfkc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_value_next  = pend_value_reg;
                    state_next      = mtfkc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mtfkc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/mtfkc_checker.sv
// Port-level assertions for the move-to-front key cache, bound to its top level.
`default_nettype none

module mtfkc_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 req_valid,
    input wire                                 req_ready,
    input wire                                 rsp_valid,
    input wire                                 rsp_ready,
    input wire [mtfkc_pkg::STATUS_W-1:0]       rsp_status,
    input wire [mtfkc_pkg::VALUE_W-1:0]        rsp_read_value
);

    // a pending result is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= mtfkc_pkg::STATUS_MISS))
        else $error("undefined status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != mtfkc_pkg::STATUS_HIT) |-> (rsp_read_value == '0))
        else $error("read value not zero outside a get hit");

endmodule

bind move_to_front_key_cache_top mtfkc_checker u_mtfkc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value)
);

`default_nettype wire
